@@ src/tslb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tslb_pkg;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam int         TAB_STOP = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TAB,
        S_PUT,
        S_DONE
    } t_state;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic append_byte;
        logic append_space;
        logic clear;
        logic rd_issue;
        logic load_out;
    } t_dp_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        t_cmd cmd;
        logic is_cr;
        logic is_lf;
        logic is_tab;
        logic len_full;
        logic len_zero;
        logic tab_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ src/text_scrollback_line_buffer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tuser cmd, s_tdata byte, row, column
// m_*       out  m_tvalid / m_tready       m_tdata char, present, count, length
//
// a transaction steps through accept, execute in the sequencer, load the result register
// a tab appends spaces up to the next tab stop, one space per cycle through the single write port
// any other byte on a full line adds a commit step before the append
// reset is synchronous, active low; the store needs no clearing pass, lengths
// and the ring pointers bound every read
// a stalled m_tready holds the finished transaction in the sequencer until the result
// register frees

module text_scrollback_line_buffer_unit
    import tslb_pkg::*;
#(
    parameter int RING_LINES = 100,
    parameter int LINE_CHARS = 112
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], row[14:8], column[21:15]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // read_char[7:0], row_present[8],
                                        // line_count[15:9], current_length[22:16]
);

    t_dp_cmd    ctl;
    t_dp_sts    sts;
    logic [7:0] read_char;
    logic       row_present;
    logic [6:0] line_count;
    logic [6:0] current_length;

    tslb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    tslb_dp #(
        .RING_LINES (RING_LINES),
        .LINE_CHARS (LINE_CHARS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_tuser),
        .i_data_byte      (s_tdata[7:0]),
        .i_row            (s_tdata[14:8]),
        .i_column         (s_tdata[21:15]),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .o_read_char      (read_char),
        .o_row_present    (row_present),
        .o_line_count     (line_count),
        .o_current_length (current_length)
    );

    assign m_tdata = {1'b0, current_length, line_count, row_present, read_char};

endmodule

`default_nettype wire

@@ src/tslb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tslb_ctrl
    import tslb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.cmd)
                    CMD_PUT: begin
                        priority if (i_sts.is_cr) begin
                            n_state = S_DONE;
                        end else if (i_sts.is_lf) begin
                            o_ctl.commit = 1'b1;
                            n_state      = S_DONE;
                        end else if (i_sts.is_tab) begin
                            n_state = S_TAB;
                        end else if (i_sts.len_full) begin
                            // full line goes out first, byte lands on the fresh line
                            o_ctl.commit = 1'b1;
                            n_state      = S_PUT;
                        end else begin
                            o_ctl.append_byte = 1'b1;
                            n_state           = S_DONE;
                        end
                    end
                    CMD_READ: begin
                        o_ctl.rd_issue = 1'b1;
                        n_state        = S_DONE;
                    end
                    CMD_CLEAR: begin
                        o_ctl.clear = 1'b1;
                        n_state     = S_DONE;
                    end
                    CMD_FLUSH: begin
                        o_ctl.commit = !i_sts.len_zero;
                        n_state      = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_TAB: begin
                o_ctl.append_space = !i_sts.len_full;
                if (i_sts.tab_last) begin
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                o_ctl.append_byte = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                // hold here while the previous result is still waiting
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ src/tslb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tslb_dp
    import tslb_pkg::*;
#(
    parameter int RING_LINES = 100,
    parameter int LINE_CHARS = 112
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [6:0] i_row,
    input  wire logic [6:0] i_column,
    input  wire t_dp_cmd    i_ctl,
    output t_dp_sts         o_sts,
    output logic [7:0]      o_read_char,
    output logic            o_row_present,
    output logic [6:0]      o_line_count,
    output logic [6:0]      o_current_length
);

    // one spare slot holds the line being built, so a commit is a pointer step
    localparam int SLOTS = RING_LINES + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(LINE_CHARS);
    localparam int LW    = $clog2(LINE_CHARS + 1);
    localparam int NW    = $clog2(RING_LINES + 1);
    localparam int XW    = (NW > 7) ? NW : 7;
    localparam int YW    = (LW > 7) ? LW : 7;
    localparam int DEPTH = SLOTS * (2 ** CW);

    logic [7:0]    r_chars [0:DEPTH-1];
    logic [LW-1:0] r_lens  [0:SLOTS-1];

    logic [SW-1:0] r_op, n_op;
    logic [SW-1:0] r_bslot, n_bslot;
    logic [NW-1:0] r_count, n_count;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_text_end, n_text_end;

    t_cmd          r_cmd;
    logic [7:0]    r_byte;
    logic [6:0]    r_row;
    logic [6:0]    r_col;

    logic [7:0]    r_char_q;
    logic [LW-1:0] r_len_q;
    logic          r_rd_ring;
    logic          r_rd_cur;

    logic [7:0]    r_out_char;
    logic          r_out_present;
    logic [6:0]    r_out_count;
    logic [6:0]    r_out_len;

    logic [SW-1:0] op_inc, bslot_inc;
    logic          ring_full;
    logic [LW-1:0] len_inc;
    logic [7:0]    app_val;
    logic          app_en;
    logic [XW-1:0] row_x, count_x;
    logic          rd_ring, rd_cur;
    logic [SW:0]   rd_sum;
    logic [SW-1:0] rd_slot;
    logic [YW-1:0] col_y, len_sel_y;
    logic          col_hit;

    assign op_inc    = (r_op == SW'(SLOTS - 1)) ? '0 : r_op + 1'b1;
    assign bslot_inc = (r_bslot == SW'(SLOTS - 1)) ? '0 : r_bslot + 1'b1;
    assign ring_full = (r_count == NW'(RING_LINES));
    assign len_inc   = r_len + 1'b1;
    assign app_en    = i_ctl.append_byte || i_ctl.append_space;
    assign app_val   = i_ctl.append_space ? CH_SPACE : r_byte;

    always_comb begin
        n_op       = r_op;
        n_bslot    = r_bslot;
        n_count    = r_count;
        n_len      = r_len;
        n_text_end = r_text_end;
        priority if (i_ctl.clear) begin
            n_op       = '0;
            n_bslot    = '0;
            n_count    = '0;
            n_len      = '0;
            n_text_end = '0;
        end else if (i_ctl.commit) begin
            n_bslot    = bslot_inc;
            n_len      = '0;
            n_text_end = '0;
            if (ring_full) begin
                n_op = op_inc;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (app_en) begin
            n_len = len_inc;
            // visible text stops at the first zero byte
            if (r_text_end == r_len && app_val != 8'd0) begin
                n_text_end = len_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= '0;
            r_bslot    <= '0;
            r_count    <= '0;
            r_len      <= '0;
            r_text_end <= '0;
        end else begin
            r_op       <= n_op;
            r_bslot    <= n_bslot;
            r_count    <= n_count;
            r_len      <= n_len;
            r_text_end <= n_text_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_byte <= i_data_byte;
            r_row  <= i_row;
            r_col  <= i_column;
        end
    end

    // read address
    assign row_x   = XW'(r_row);
    assign count_x = XW'(r_count);
    assign rd_ring = row_x < count_x;
    assign rd_cur  = (row_x == count_x) && (r_len != '0);
    assign rd_sum  = {1'b0, r_op} + {1'b0, SW'(r_row)};
    always_comb begin
        if (!rd_ring) begin
            rd_slot = r_bslot;
        end else if (rd_sum >= (SW + 1)'(SLOTS)) begin
            rd_slot = SW'(rd_sum - (SW + 1)'(SLOTS));
        end else begin
            rd_slot = rd_sum[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (app_en) begin
            r_chars[{r_bslot, r_len[CW-1:0]}] <= app_val;
        end
        if (i_ctl.rd_issue) begin
            r_char_q <= r_chars[{rd_slot, CW'(r_col)}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_lens[r_bslot] <= r_text_end;
        end
        if (i_ctl.rd_issue) begin
            r_len_q   <= r_lens[rd_slot];
            r_rd_ring <= rd_ring;
            r_rd_cur  <= rd_cur;
        end
    end

    assign col_y     = YW'(r_col);
    assign len_sel_y = r_rd_ring ? YW'(r_len_q) : YW'(r_text_end);
    assign col_hit   = col_y < len_sel_y;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            if (r_cmd == CMD_READ) begin
                r_out_present <= r_rd_ring || r_rd_cur;
                r_out_char    <= ((r_rd_ring || r_rd_cur) && col_hit) ? r_char_q : 8'd0;
            end else begin
                r_out_present <= 1'b0;
                r_out_char    <= 8'd0;
            end
            r_out_count <= 7'(r_count);
            r_out_len   <= 7'(r_len);
        end
    end

    assign o_read_char      = r_out_char;
    assign o_row_present    = r_out_present;
    assign o_line_count     = r_out_count;
    assign o_current_length = r_out_len;

    assign o_sts.cmd      = r_cmd;
    assign o_sts.is_cr    = (r_byte == CH_CR);
    assign o_sts.is_lf    = (r_byte == CH_LF);
    assign o_sts.is_tab   = (r_byte == CH_TAB);
    assign o_sts.len_full = (r_len >= LW'(LINE_CHARS));
    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.tab_last = (r_len >= LW'(LINE_CHARS))
                         || ((len_inc & LW'(TAB_STOP - 1)) == '0)
                         || (len_inc >= LW'(LINE_CHARS));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(RING_LINES))
        else $error("committed count above ring size");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LINE_CHARS) && r_text_end <= r_len)
        else $error("line length or text end out of range");

    a_bslot_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((SW + NW + 1)'(r_op) + (SW + NW + 1)'(r_count) == (SW + NW + 1)'(r_bslot))
        || ((SW + NW + 1)'(r_op) + (SW + NW + 1)'(r_count)
            == (SW + NW + 1)'(r_bslot) + (SW + NW + 1)'(SLOTS)))
        else $error("build slot does not follow the newest line");

    a_commit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |=> r_len == '0 && r_text_end == '0)
        else $error("line not emptied after commit");

endmodule

`default_nettype wire
